// ===== rtl/core/stts_pkg.sv =====
// Package for the sorted time table search block.
// Holds the beat types, opcode and sequencer state codes and shared constants.
// No dependencies.
package stts_pkg;

  // Default table depth
  localparam int TABLE_ENTRIES_DEF = 256;

  // Largest accepted timestamp: 100:39.999 in milliseconds
  localparam logic [31:0] MAX_STAMP = 32'd6039999;

  localparam int TIME_W  = 23;
  localparam int KEY_W   = 32;
  localparam int INDEX_W = 8;
  localparam int RES_W   = 9;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_FIND   = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_TEST,
    ST_INS_CMP,
    ST_FND_TEST,
    ST_FND_CMP,
    ST_RD_WAIT,
    ST_DONE
  } state_t;

  // Command beat
  typedef struct packed {
    op_t                  opcode;
    logic [KEY_W-1:0]     time_value;
    logic [INDEX_W-1:0]   entry_index;
  } cmd_t;

  // Result beat
  typedef struct packed {
    logic signed [RES_W-1:0] found_index;
    logic [TIME_W-1:0]       entry_time;
    logic                    entry_valid;
    logic                    rejected;
    logic [RES_W-1:0]        entry_count;
  } res_t;

  // Sequencer status toward the output stage
  typedef struct packed {
    logic idle;
    logic done;
  } status_t;

endpackage

// ===== rtl/core/sorted_time_table_search.sv =====
// Top level of the sorted time table search block.
// Depends on stts_pkg, stts_ram, stts_cmp and stts_ctrl; holds the result register.
//
//  channel | dir | handshake           | beat
//  --------+-----+---------------------+---------------------------------
//  cmd     | in  | cmd_valid/cmd_stall | opcode, time_value, entry_index
//  res     | out | res_valid/res_stall | found_index .. entry_count
//
// Each probe is one registered read of the single RAM read port, then
// one pass through the shared comparator.
// Reset clears the count and the sequencer; table contents are not cleared.
// A finished result waits in the sequencer while the result register is stalled.
module sorted_time_table_search #(
  parameter int TABLE_ENTRIES = stts_pkg::TABLE_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  stts_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_stall,
  output stts_pkg::res_t res
);

  localparam int AW = $clog2(TABLE_ENTRIES);

  stts_pkg::status_t status;
  stts_pkg::res_t    result;
  logic              take;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [AW-1:0]               ram_raddr;
  logic [stts_pkg::TIME_W-1:0] ram_wdata;
  logic [stts_pkg::TIME_W-1:0] ram_rdata;
  logic [stts_pkg::TIME_W-1:0] cmp_stamp;
  logic [stts_pkg::KEY_W-1:0]  cmp_key;
  logic                        cmp_gt;

  assign cmd_stall = !status.idle;
  assign take      = !res_valid || !res_stall;

  stts_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .take      (take),
    .status    (status),
    .result    (result),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .cmp_stamp (cmp_stamp),
    .cmp_key   (cmp_key),
    .cmp_gt    (cmp_gt)
  );

  stts_ram #(
    .WIDTH (stts_pkg::TIME_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  stts_cmp u_cmp (
    .stamp (cmp_stamp),
    .key   (cmp_key),
    .gt    (cmp_gt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (status.done && take) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.done && take) begin
      res <= result;
    end
  end

endmodule

// ===== rtl/core/stts_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module stts_ram #(
  parameter int WIDTH = 23,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/stts_cmp.sv =====
// Shared magnitude comparator: stored timestamp against the latched key.
// Depends on stts_pkg for field widths.
module stts_cmp (
  input  logic [stts_pkg::TIME_W-1:0] stamp,
  input  logic [stts_pkg::KEY_W-1:0]  key,
  output logic                        gt
);

  // Stamp zero-extended to the key width
  assign gt = stts_pkg::KEY_W'(stamp) > key;

endmodule

// ===== rtl/core/stts_ctrl.sv =====
// Sequencer for clear, insert (shift toward the tail), find (binary search) and read.
// Depends on stts_pkg; drives the table RAM and the shared comparator.
module stts_ctrl #(
  parameter int TABLE_ENTRIES = stts_pkg::TABLE_ENTRIES_DEF,
  localparam int AW   = $clog2(TABLE_ENTRIES),
  localparam int CW   = $clog2(TABLE_ENTRIES + 1),
  localparam int CMPW = (CW > stts_pkg::INDEX_W) ? CW : stts_pkg::INDEX_W
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  input  stts_pkg::cmd_t               cmd,
  input  logic                         take,
  output stts_pkg::status_t            status,
  output stts_pkg::res_t               result,
  output logic                         ram_we,
  output logic [AW-1:0]                ram_waddr,
  output logic [stts_pkg::TIME_W-1:0]  ram_wdata,
  output logic [AW-1:0]                ram_raddr,
  input  logic [stts_pkg::TIME_W-1:0]  ram_rdata,
  output logic [stts_pkg::TIME_W-1:0]  cmp_stamp,
  output logic [stts_pkg::KEY_W-1:0]   cmp_key,
  input  logic                         cmp_gt
);

  stts_pkg::state_t state, state_next;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] p, p_next;
  logic [CW-1:0] lo, lo_next;
  logic [CW-1:0] hi, hi_next;
  logic [CW-1:0] mid, mid_next;
  logic [CW:0]   mid_sum;
  logic [stts_pkg::KEY_W-1:0] key, key_next;
  logic signed [stts_pkg::RES_W-1:0] found, found_next;
  logic [stts_pkg::TIME_W-1:0] etime, etime_next;
  logic evalid, evalid_next;
  logic rej, rej_next;

  // State and count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stts_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    p      <= p_next;
    lo     <= lo_next;
    hi     <= hi_next;
    mid    <= mid_next;
    key    <= key_next;
    found  <= found_next;
    etime  <= etime_next;
    evalid <= evalid_next;
    rej    <= rej_next;
  end

  assign cmp_stamp = ram_rdata;
  assign cmp_key   = key;
  assign mid_sum   = (CW + 1)'(lo) + (CW + 1)'(hi);

  // Next state and datapath control
  always_comb begin
    state_next  = state;
    count_next  = count;
    p_next      = p;
    lo_next     = lo;
    hi_next     = hi;
    mid_next    = mid;
    key_next    = key;
    found_next  = found;
    etime_next  = etime;
    evalid_next = evalid;
    rej_next    = rej;
    ram_we      = 1'b0;
    ram_waddr   = AW'(p);
    ram_wdata   = key[stts_pkg::TIME_W-1:0];
    ram_raddr   = '0;

    unique case (state)
      stts_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          key_next    = cmd.time_value;
          found_next  = -9'sd1;
          etime_next  = '0;
          evalid_next = 1'b0;
          rej_next    = 1'b0;
          unique case (cmd.opcode)
            stts_pkg::OP_CLEAR: begin
              count_next = '0;
              state_next = stts_pkg::ST_DONE;
            end
            stts_pkg::OP_INSERT: begin
              if (cmd.time_value > stts_pkg::MAX_STAMP || count == CW'(TABLE_ENTRIES)) begin
                rej_next   = 1'b1;
                state_next = stts_pkg::ST_DONE;
              end else begin
                p_next     = count;
                state_next = stts_pkg::ST_INS_TEST;
              end
            end
            stts_pkg::OP_FIND: begin
              lo_next    = '0;
              hi_next    = count;
              state_next = stts_pkg::ST_FND_TEST;
            end
            stts_pkg::OP_READ: begin
              if (CMPW'(cmd.entry_index) < CMPW'(count)) begin
                ram_raddr  = AW'(cmd.entry_index);
                state_next = stts_pkg::ST_RD_WAIT;
              end else begin
                state_next = stts_pkg::ST_DONE;
              end
            end
            default: state_next = stts_pkg::ST_DONE;
          endcase
        end
      end

      // Insert: walk down from the tail, moving larger entries up one slot
      stts_pkg::ST_INS_TEST: begin
        if (p == '0) begin
          ram_we     = 1'b1;
          count_next = count + CW'(1);
          state_next = stts_pkg::ST_DONE;
        end else begin
          ram_raddr  = AW'(p - CW'(1));
          state_next = stts_pkg::ST_INS_CMP;
        end
      end

      stts_pkg::ST_INS_CMP: begin
        ram_we = 1'b1;
        if (cmp_gt) begin
          ram_wdata  = ram_rdata;
          p_next     = p - CW'(1);
          state_next = stts_pkg::ST_INS_TEST;
        end else begin
          count_next = count + CW'(1);
          state_next = stts_pkg::ST_DONE;
        end
      end

      // Find: lo counts entries known to be at or before the key
      stts_pkg::ST_FND_TEST: begin
        if (lo == hi) begin
          found_next = $signed(stts_pkg::RES_W'(lo) - 9'd1);
          state_next = stts_pkg::ST_DONE;
        end else begin
          mid_next   = mid_sum[CW:1];
          ram_raddr  = AW'(mid_sum[CW:1]);
          state_next = stts_pkg::ST_FND_CMP;
        end
      end

      stts_pkg::ST_FND_CMP: begin
        if (cmp_gt) begin
          hi_next = mid;
        end else begin
          lo_next = mid + CW'(1);
        end
        state_next = stts_pkg::ST_FND_TEST;
      end

      stts_pkg::ST_RD_WAIT: begin
        etime_next  = ram_rdata;
        evalid_next = 1'b1;
        state_next  = stts_pkg::ST_DONE;
      end

      stts_pkg::ST_DONE: begin
        if (take) begin
          state_next = stts_pkg::ST_IDLE;
        end
      end

      default: state_next = stts_pkg::ST_IDLE;
    endcase
  end

  assign status.idle = (state == stts_pkg::ST_IDLE);
  assign status.done = (state == stts_pkg::ST_DONE);

  assign result.found_index = found;
  assign result.entry_time  = etime;
  assign result.entry_valid = evalid;
  assign result.rejected    = rej;
  assign result.entry_count = stts_pkg::RES_W'(count);

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_ENTRIES))
    else $error("table count above depth");

  a_write_only_insert: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == stts_pkg::ST_INS_TEST || state == stts_pkg::ST_INS_CMP))
    else $error("table written outside insert");

  a_shift_not_at_head: assert property (@(posedge clk) disable iff (rst)
    state == stts_pkg::ST_INS_CMP |-> p != '0 && p <= count)
    else $error("insert shift position out of range");

  a_search_window: assert property (@(posedge clk) disable iff (rst)
    (state == stts_pkg::ST_FND_TEST || state == stts_pkg::ST_FND_CMP) |-> lo <= hi && hi <= count)
    else $error("search window inverted");

  a_probe_inside: assert property (@(posedge clk) disable iff (rst)
    state == stts_pkg::ST_FND_CMP |-> mid < count && mid >= lo && mid < hi)
    else $error("search probe outside table");

endmodule

// ===== bench/tb.sv =====
// Testbench for sorted_time_table_search: directed table, then random load/search phases.
// Depends on stts_pkg and the RTL of the block; every result beat is checked against
// an in-bench table predictor, or against the typed beat where one is given.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stts_pkg::*;

  localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
  localparam int TABLE_AW      = $clog2(TABLE_ENTRIES);
  localparam int ITEMS_TARGET  = 1950;
  localparam int CYCLE_LIMIT   = 5_000_000;
  localparam int DRAIN_CYCLES  = 16;

  // Directed row: command, whether the expected beat is typed in, and that beat
  typedef struct packed {
    cmd_t cmd;
    bit   typed;
    res_t want;
  } row_t;

  localparam res_t NO_RES = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  // Predictor state
  logic [TIME_W-1:0] stamp_table [TABLE_ENTRIES];
  int                stamp_count = 0;

  res_t pending_results [$];
  int   mismatch_count = 0;
  int   sent_items = 0;
  bit   quiet_sender = 1'b0;

  // Expected beats are typed in for reset, extremes and rejects; zero "want" rows use
  // the predictor. Table after row 9: 0, 1000, 60000, 60000, 6039999.
  row_t plan [25] = '{
    '{'{OP_READ,   32'd0,          8'd0},   1'b1, '{-9'sd1, 23'd0, 1'b0, 1'b0, 9'd0}},
    '{'{OP_FIND,   32'd0,          8'd0},   1'b1, '{-9'sd1, 23'd0, 1'b0, 1'b0, 9'd0}},
    '{'{OP_FIND,   32'hFFFF_FFFF,  8'hFF},  1'b1, '{-9'sd1, 23'd0, 1'b0, 1'b0, 9'd0}},
    '{'{OP_INSERT, 32'd6040000,    8'd0},   1'b1, '{-9'sd1, 23'd0, 1'b0, 1'b1, 9'd0}},
    '{'{OP_INSERT, 32'hFFFF_FFFF,  8'hFF},  1'b1, '{-9'sd1, 23'd0, 1'b0, 1'b1, 9'd0}},
    '{'{OP_INSERT, 32'd6039999,    8'd0},   1'b1, '{-9'sd1, 23'd0, 1'b0, 1'b0, 9'd1}},
    '{'{OP_INSERT, 32'd0,          8'd0},   1'b1, '{-9'sd1, 23'd0, 1'b0, 1'b0, 9'd2}},
    '{'{OP_INSERT, 32'd60000,      8'd0},   1'b1, '{-9'sd1, 23'd0, 1'b0, 1'b0, 9'd3}},
    '{'{OP_INSERT, 32'd60000,      8'd0},   1'b1, '{-9'sd1, 23'd0, 1'b0, 1'b0, 9'd4}},
    '{'{OP_INSERT, 32'd1000,       8'd0},   1'b1, '{-9'sd1, 23'd0, 1'b0, 1'b0, 9'd5}},
    '{'{OP_FIND,   32'd0,          8'd0},   1'b1, '{9'sd0, 23'd0, 1'b0, 1'b0, 9'd5}},
    '{'{OP_FIND,   32'd59999,      8'd0},   1'b0, NO_RES},
    '{'{OP_FIND,   32'd60000,      8'd0},   1'b0, NO_RES},
    '{'{OP_FIND,   32'hFFFF_FFFF,  8'd0},   1'b1, '{9'sd4, 23'd0, 1'b0, 1'b0, 9'd5}},
    '{'{OP_READ,   32'd0,          8'd0},   1'b1, '{-9'sd1, 23'd0, 1'b1, 1'b0, 9'd5}},
    '{'{OP_READ,   32'hFFFF_FFFF,  8'd4},   1'b1, '{-9'sd1, 23'd6039999, 1'b1, 1'b0, 9'd5}},
    '{'{OP_READ,   32'd0,          8'd5},   1'b1, '{-9'sd1, 23'd0, 1'b0, 1'b0, 9'd5}},
    '{'{OP_READ,   32'd0,          8'hFF},  1'b1, '{-9'sd1, 23'd0, 1'b0, 1'b0, 9'd5}},
    '{'{OP_CLEAR,  32'hFFFF_FFFF,  8'hFF},  1'b1, '{-9'sd1, 23'd0, 1'b0, 1'b0, 9'd0}},
    '{'{OP_FIND,   32'd1000,       8'd0},   1'b1, '{-9'sd1, 23'd0, 1'b0, 1'b0, 9'd0}},
    '{'{OP_READ,   32'd0,          8'd0},   1'b1, '{-9'sd1, 23'd0, 1'b0, 1'b0, 9'd0}},
    '{'{OP_INSERT, 32'd5000,       8'h55},  1'b0, NO_RES},
    '{'{OP_FIND,   32'd4999,       8'd0},   1'b0, NO_RES},
    '{'{OP_FIND,   32'd5000,       8'd0},   1'b0, NO_RES},
    '{'{OP_READ,   32'd0,          8'd1},   1'b0, NO_RES}
  };

  sorted_time_table_search #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

  always #5 clk = ~clk;

  // Table predictor: applies one command and returns the beat it produces
  function automatic res_t apply_table_cmd(input cmd_t c);
    res_t r;
    int   slot;
    r = '0;
    r.found_index = '1;
    case (c.opcode)
      OP_CLEAR: stamp_count = 0;
      OP_INSERT: begin
        if (c.time_value > MAX_STAMP || stamp_count >= TABLE_ENTRIES) begin
          r.rejected = 1'b1;
        end else begin
          // equal stamps keep arrival order: new one lands after them
          slot = stamp_count;
          while (slot > 0 && stamp_table[TABLE_AW'(slot-1)] > c.time_value) begin
            stamp_table[TABLE_AW'(slot)] = stamp_table[TABLE_AW'(slot-1)];
            slot--;
          end
          stamp_table[TABLE_AW'(slot)] = c.time_value[TIME_W-1:0];
          stamp_count++;
        end
      end
      OP_FIND: begin
        for (int i = 0; i < stamp_count; i++)
          if (stamp_table[TABLE_AW'(i)] <= c.time_value) r.found_index = RES_W'(i);
      end
      default: begin
        if (int'(c.entry_index) < stamp_count) begin
          r.entry_valid = 1'b1;
          r.entry_time  = stamp_table[TABLE_AW'(c.entry_index)];
        end
      end
    endcase
    r.entry_count = RES_W'(stamp_count);
    return r;
  endfunction

  function automatic int unsigned draw_wait(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic cmd_t make_cmd(input op_t op, input logic [KEY_W-1:0] tv,
                                    input logic [INDEX_W-1:0] ix);
    cmd_t c;
    c.opcode      = op;
    c.time_value  = tv;
    c.entry_index = ix;
    return c;
  endfunction

  // Stamp in range; coarse mode packs values onto few seconds to force duplicates
  function automatic logic [KEY_W-1:0] random_stamp(input bit coarse);
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return MAX_STAMP;
    if (coarse) return KEY_W'($urandom_range(0, 20) * 1000);
    return KEY_W'($urandom_range(0, 6039999));
  endfunction

  // Mixed traffic on a loaded table
  function automatic cmd_t random_command(input bit coarse);
    cmd_t        c;
    int unsigned pick;
    int unsigned near;
    c.time_value  = $urandom();
    c.entry_index = INDEX_W'($urandom_range(0, 255));
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      c.opcode = OP_CLEAR;
    end else if (pick <= 5) begin
      c.opcode = OP_INSERT;
      if ($urandom_range(0, 3) != 0)
        c.time_value = random_stamp(coarse);
      else if ($urandom_range(0, 1) == 0)
        c.time_value = MAX_STAMP + 32'd1 + KEY_W'($urandom_range(0, 1000));
    end else if (pick <= 12) begin
      c.opcode = OP_FIND;
      near = $urandom_range(0, 3);
      // probe just below, at and just above a stored stamp
      if (stamp_count > 0 && near < 3)
        c.time_value = KEY_W'(stamp_table[TABLE_AW'($urandom_range(0, stamp_count - 1))])
                       + KEY_W'(near) - 32'd1;
      else if ($urandom_range(0, 1) == 0)
        c.time_value = random_stamp(coarse);
    end else begin
      c.opcode = OP_READ;
      if ($urandom_range(0, 3) != 0)
        c.entry_index = INDEX_W'($urandom_range(0,
                          (stamp_count + 2 > 255) ? 255 : stamp_count + 2));
    end
    return c;
  endfunction

  // Drive one command beat; typed expectation replaces the predicted one when given
  task automatic send_command(input cmd_t c, input bit typed = 1'b0,
                              input res_t want = '0);
    int unsigned gap;
    res_t        predicted;
    gap = draw_wait(quiet_sender);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    @(posedge clk);
    while (cmd_stall !== 1'b0) @(posedge clk);
    predicted = apply_table_cmd(c);
    pending_results.push_back(typed ? want : predicted);
    sent_items++;
  endtask

  // Stimulus
  initial begin : stimulus
    int unsigned fill;
    bit          coarse;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_command(plan[i].cmd, plan[i].typed, plan[i].want);

    // Phases: usually clear, load the table, then mixed traffic on it
    while (sent_items < ITEMS_TARGET) begin
      quiet_sender = ($urandom_range(0, 3) == 0);
      coarse = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 3) != 0)
        send_command(make_cmd(OP_CLEAR, $urandom(), INDEX_W'($urandom())));
      fill = ($urandom_range(0, 9) == 0) ? TABLE_ENTRIES + $urandom_range(0, 3)
                                         : $urandom_range(1, 24);
      repeat (fill)
        send_command(make_cmd(OP_INSERT, random_stamp(coarse), INDEX_W'($urandom())));
      repeat ($urandom_range(10, 40)) send_command(random_command(coarse));
    end
    cmd_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Result side: random stall per beat, with unstalled stretches
  initial begin : result_check
    int unsigned hold;
    int unsigned beats;
    res_t        want;
    beats = 0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      hold = (beats % 96 < 24) ? 0 : draw_wait(1'b0);
      if (hold > 0) begin
        res_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      res_stall <= 1'b0;
      @(posedge clk);
      while (res_valid !== 1'b1) @(posedge clk);
      beats++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat found=%0d time=%0d valid=%0b rej=%0b count=%0d",
                 $time, res.found_index, res.entry_time, res.entry_valid, res.rejected,
                 res.entry_count);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (res !== want) begin
          $display("%0t: expected found=%0d time=%0d valid=%0b rej=%0b count=%0d",
                   $time, want.found_index, want.entry_time, want.entry_valid,
                   want.rejected, want.entry_count);
          $display("%0t:   actual found=%0d time=%0d valid=%0b rej=%0b count=%0d",
                   $time, res.found_index, res.entry_time, res.entry_valid,
                   res.rejected, res.entry_count);
          mismatch_count++;
        end
      end
    end
  end

  // Cycle limit
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

endmodule
